[rtl/graph_depth_first_search_assert.svh]
// Assertion macros shared by the depth-first search block.
`ifndef GRAPH_DEPTH_FIRST_SEARCH_ASSERT_SVH
`define GRAPH_DEPTH_FIRST_SEARCH_ASSERT_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define GDFS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond holds in every cycle out of reset
`define GDFS_ASSERT_ALWAYS(label, cond, msg) \
    `GDFS_ASSERT_IMPLY(label, 1'b1, cond, msg)

`endif

[rtl/gdfs_pkg.sv]
// Types and constants of the depth-first search block.
`timescale 1ns / 1ps

package gdfs_pkg;

    localparam int VTX_W         = 4;
    localparam int NUM_VERTICES  = 1 << VTX_W;
    localparam int CNT_W         = $clog2(NUM_VERTICES + 1);
    localparam int CFG_W         = 5;
    localparam int CFG_RESET     = 16;
    localparam int STACK_DEPTH   = 256;
    localparam int STACK_ADDR_W  = $clog2(STACK_DEPTH);
    localparam int LVL_W         = $clog2(STACK_DEPTH + 1);
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic [1:0]       action;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
    } cmd_beat_t;

    typedef struct packed {
        logic [VTX_W-1:0] visited_vertex;
        logic             last;
        logic             overflow;
    } res_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_POP_WAIT,
        ST_SCAN,
        ST_FINISH
    } gdfs_state_t;

endpackage

[rtl/graph_depth_first_search.sv]
// Depth-first search over a bit adjacency matrix, one sequencer with a stack memory.
// Clear and add-edge beats are applied from ST_IDLE; the block is ready again on the next cycle.
// Search: the accept pushes the start vertex; each pop passes ST_POP and ST_POP_WAIT, each
// visited vertex scans min(vertex_count, 16) row bits in ST_SCAN, and ST_FINISH sends the last
// beat; output stalls can hold the search. One item at a time; results stream out while it runs.
// Reset (rst_n low, async) clears matrix, marks and stack level; vertex_count is 16.
`timescale 1ns / 1ps
`include "graph_depth_first_search_assert.svh"

module graph_depth_first_search
    import gdfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cmd_beat_t             cmd,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_beat_t             res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    gdfs_state_t                  state_reg, state_next;
    logic [NUM_VERTICES-1:0]      adj_reg [NUM_VERTICES];
    logic [NUM_VERTICES-1:0]      adj_next [NUM_VERTICES];
    logic [NUM_VERTICES-1:0]      marks_reg, marks_next;
    logic [NUM_VERTICES-1:0]      row_reg, row_next;
    logic [LVL_W-1:0]             level_reg, level_next;
    logic [CNT_W-1:0]             w_reg, w_next;
    logic [VTX_W-1:0]             pend_vertex_reg, pend_vertex_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic                         ovf_reg, ovf_next;
    logic                         out_valid_reg, out_valid_next;
    res_beat_t                    out_data_reg, out_data_next;
    logic [CFG_W-1:0]             vertex_count_reg;

    logic [VTX_W-1:0]             stack_mem [STACK_DEPTH];
    logic [VTX_W-1:0]             pop_data_reg;
    logic                         push_en, pop_en;
    logic [STACK_ADDR_W-1:0]      push_addr, pop_addr;
    logic [VTX_W-1:0]             push_data;
    logic [LVL_W-1:0]             level_dec;

    logic                         out_free;
    logic [CNT_W-1:0]             n_eff;
    logic                         cfg_write;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
    assign prdata    = (paddr[2] == REG_VERTEX_COUNT)
                     ? {{(APB_DATA_W-CFG_W){1'b0}}, vertex_count_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= CFG_W'(CFG_RESET);
        end
        else if (cfg_write)
        begin
            vertex_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign n_eff = (vertex_count_reg > CFG_W'(NUM_VERTICES))
                 ? CNT_W'(NUM_VERTICES) : CNT_W'(vertex_count_reg);

    // stack memory
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[push_addr] <= push_data;
        end
        if (pop_en)
        begin
            pop_data_reg <= stack_mem[pop_addr];
        end
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;
    assign out_free  = !out_valid_reg || !res_stall;
    assign level_dec = level_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            marks_reg      <= '0;
            level_reg      <= '0;
            w_reg          <= '0;
            pend_valid_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_VERTICES; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            marks_reg      <= marks_next;
            level_reg      <= level_next;
            w_reg          <= w_next;
            pend_valid_reg <= pend_valid_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
            for (int i = 0; i < NUM_VERTICES; i++)
            begin
                adj_reg[i] <= adj_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg         <= row_next;
        pend_vertex_reg <= pend_vertex_next;
        out_data_reg    <= out_data_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        marks_next       = marks_reg;
        row_next         = row_reg;
        level_next       = level_reg;
        w_next           = w_reg;
        pend_vertex_next = pend_vertex_reg;
        pend_valid_next  = pend_valid_reg;
        ovf_next         = ovf_reg;
        out_valid_next   = out_valid_reg && res_stall;
        out_data_next    = out_data_reg;
        push_en          = 1'b0;
        pop_en           = 1'b0;
        push_addr        = level_reg[STACK_ADDR_W-1:0];
        pop_addr         = level_dec[STACK_ADDR_W-1:0];
        push_data        = w_reg[VTX_W-1:0];
        for (int i = 0; i < NUM_VERTICES; i++)
        begin
            adj_next[i] = adj_reg[i];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.action)
                        ACT_CLEAR:
                        begin
                            for (int i = 0; i < NUM_VERTICES; i++)
                            begin
                                adj_next[i] = '0;
                            end
                        end
                        ACT_ADD:
                        begin
                            adj_next[cmd.vertex_a][cmd.vertex_b] = 1'b1;
                            adj_next[cmd.vertex_b][cmd.vertex_a] = 1'b1;
                        end
                        ACT_SEARCH:
                        begin
                            push_en         = 1'b1;
                            push_addr       = '0;
                            push_data       = cmd.vertex_a;
                            level_next      = LVL_W'(1);
                            marks_next      = '0;
                            pend_valid_next = 1'b0;
                            ovf_next        = 1'b0;
                            state_next      = ST_POP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                if (level_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    pop_en     = 1'b1;
                    level_next = level_dec;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                if (marks_reg[pop_data_reg])
                begin
                    state_next = ST_POP;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next               = 1'b1;
                        out_data_next.visited_vertex = pend_vertex_reg;
                        out_data_next.last           = 1'b0;
                        out_data_next.overflow       = 1'b0;
                    end
                    marks_next[pop_data_reg] = 1'b1;
                    pend_vertex_next         = pop_data_reg;
                    pend_valid_next          = 1'b1;
                    row_next                 = adj_reg[pop_data_reg];
                    w_next                   = '0;
                    state_next               = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (w_reg >= n_eff)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    w_next = w_reg + 1'b1;
                    if (row_reg[w_reg[VTX_W-1:0]] && !marks_reg[w_reg[VTX_W-1:0]])
                    begin
                        if (level_reg == LVL_W'(STACK_DEPTH))
                        begin
                            ovf_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            push_en    = 1'b1;
                            level_next = level_reg + 1'b1;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.visited_vertex = pend_vertex_reg;
                    out_data_next.last           = 1'b1;
                    out_data_next.overflow       = ovf_reg;
                    pend_valid_next              = 1'b0;
                    level_next                   = '0;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `GDFS_ASSERT_ALWAYS(a_level_bound, level_reg <= LVL_W'(STACK_DEPTH), "stack level past depth")
    `GDFS_ASSERT_IMPLY(a_ovf_last, out_valid_reg && out_data_reg.overflow, out_data_reg.last, "overflow without last")
    `GDFS_ASSERT_IMPLY(a_pend_marked, pend_valid_reg, marks_reg[pend_vertex_reg], "pending vertex not marked")
    `GDFS_ASSERT_IMPLY(a_scan_bound, state_reg == ST_SCAN, w_reg <= CNT_W'(NUM_VERTICES), "scan index out of range")

endmodule
